/* hdl/sfb_pkg.sv */
// Shared types, constants and the CRC step for the status frame builder.
`timescale 1ns / 1ps
package sfb_pkg;

  localparam int unsigned SFB_QUEUE_DEPTH = 2;
  localparam int unsigned CFG_INDEX_W     = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_SYSTEM_ID    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_COMPONENT_ID = CFG_INDEX_W'(1);

  localparam logic [7:0]  SYSTEM_ID_RST    = 8'd51;
  localparam logic [7:0]  COMPONENT_ID_RST = 8'd68;
  localparam logic [7:0]  START_BYTE       = 8'hFE;
  localparam logic [7:0]  PAYLOAD_LEN      = 8'd9;
  localparam logic [7:0]  MSG_ID           = 8'd109;
  localparam logic [7:0]  CRC_MSG_BYTE     = 8'd185;
  localparam logic [15:0] CRC_SEED         = 16'hFFFF;
  localparam logic [15:0] FRAME_LEN        = 16'd17;

  localparam int unsigned POS_W = 5;
  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t POS_START   = POS_W'(0);
  localparam pos_t POS_LEN     = POS_W'(1);
  localparam pos_t POS_SEQ     = POS_W'(2);
  localparam pos_t POS_SYS     = POS_W'(3);
  localparam pos_t POS_COMP    = POS_W'(4);
  localparam pos_t POS_MSG     = POS_W'(5);
  localparam pos_t POS_RXE_LO  = POS_W'(6);
  localparam pos_t POS_RXE_HI  = POS_W'(7);
  localparam pos_t POS_COR_LO  = POS_W'(8);
  localparam pos_t POS_COR_HI  = POS_W'(9);
  localparam pos_t POS_LRSSI   = POS_W'(10);
  localparam pos_t POS_RRSSI   = POS_W'(11);
  localparam pos_t POS_RXBUF   = POS_W'(12);
  localparam pos_t POS_LNOISE  = POS_W'(13);
  localparam pos_t POS_RNOISE  = POS_W'(14);
  localparam pos_t POS_CRC_LO  = POS_W'(15);
  localparam pos_t POS_CRC_HI  = POS_W'(16);

  typedef struct packed {
    logic [15:0] rx_error_count;
    logic [15:0] corrected_count;
    logic [7:0]  local_rssi;
    logic [7:0]  remote_rssi;
    logic [7:0]  rx_buffer_space;
    logic [7:0]  local_noise;
    logic [7:0]  remote_noise;
    logic [7:0]  seq;
    logic [7:0]  system_id;
    logic [7:0]  component_id;
  } sfb_entry_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } sfb_q_status_t;

  function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'h0};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b0, t, 3'b0} ^ {12'h000, t[7:4]};
  endfunction

endpackage

/* hdl/sfb_if.sv */
// Channel interfaces: status report input, frame byte output, register writes.
`timescale 1ns / 1ps
interface sfb_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] rx_error_count;
  logic [15:0] corrected_count;
  logic [7:0]  local_rssi;
  logic [7:0]  remote_rssi;
  logic [7:0]  rx_buffer_space;
  logic [7:0]  local_noise;
  logic [7:0]  remote_noise;
  logic [15:0] link_room;

  modport source (output valid, output rx_error_count, output corrected_count,
                  output local_rssi, output remote_rssi, output rx_buffer_space,
                  output local_noise, output remote_noise, output link_room,
                  input ready);
  modport sink (input valid, input rx_error_count, input corrected_count,
                input local_rssi, input remote_rssi, input rx_buffer_space,
                input local_noise, input remote_noise, input link_room,
                output ready);
endinterface

interface sfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_last;

  modport source (output valid, output frame_byte, output frame_last, input ready);
  modport sink (input valid, input frame_byte, input frame_last, output ready);
endinterface

interface sfb_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/status_frame_builder_crc16_top.sv */
// Top level of the radio status frame builder.
`timescale 1ns / 1ps
// Each accepted status report with link_room of 17 or more becomes one 17-byte
// frame (start byte, length, sequence, system id, component id, message id 109,
// nine payload bytes, CRC low then high) delivered one byte per beat, with
// frame_last on the CRC high byte. The serializer emits one byte per cycle,
// while the output is ready, from a registered output stage; the running CRC
// advances one byte per cycle alongside the output. A report with link_room
// below 17 is taken, produces no bytes and still advances the sequence
// number. Up to QUEUE_DEPTH reports wait between the front end and the
// serializer, so input is taken while a frame is going out.
// Register writes (index 0 system id, 1 component id) are always ready.
module status_frame_builder_crc16_top
  import sfb_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = SFB_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  sfb_in_if.sink    in_ch,
  sfb_out_if.source out_ch,
  sfb_cfg_if.sink   cfg_ch
);

  sfb_q_status_t q_status;
  sfb_entry_t    push_entry;
  sfb_entry_t    head;
  logic          push;
  logic          pop;

  sfb_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  sfb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  sfb_serializer u_serializer (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

/* hdl/sfb_front.sv */
// Front end: register writes, sequence numbering and drop classification of reports.
`timescale 1ns / 1ps
module sfb_front
  import sfb_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  sfb_in_if.sink        in_ch,
  sfb_cfg_if.sink       cfg_ch,
  input  sfb_q_status_t q_status,
  output logic          push,
  output sfb_entry_t    push_entry
);

  logic [7:0] seq_r, seq_nxt;
  logic [7:0] system_id_r, system_id_nxt;
  logic [7:0] component_id_r, component_id_nxt;
  logic       accept;

  assign in_ch.ready  = !q_status.full;
  assign cfg_ch.ready = 1'b1;
  assign accept       = in_ch.valid && in_ch.ready;
  assign push         = accept && (in_ch.link_room >= FRAME_LEN);

  always_comb begin
    seq_nxt          = accept ? seq_r + 8'd1 : seq_r;
    system_id_nxt    = system_id_r;
    component_id_nxt = component_id_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_SYSTEM_ID:    system_id_nxt    = cfg_ch.data;
        REG_COMPONENT_ID: component_id_nxt = cfg_ch.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    push_entry.rx_error_count  = in_ch.rx_error_count;
    push_entry.corrected_count = in_ch.corrected_count;
    push_entry.local_rssi      = in_ch.local_rssi;
    push_entry.remote_rssi     = in_ch.remote_rssi;
    push_entry.rx_buffer_space = in_ch.rx_buffer_space;
    push_entry.local_noise     = in_ch.local_noise;
    push_entry.remote_noise    = in_ch.remote_noise;
    push_entry.seq             = seq_r;
    push_entry.system_id       = system_id_r;
    push_entry.component_id    = component_id_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r          <= 8'd0;
      system_id_r    <= SYSTEM_ID_RST;
      component_id_r <= COMPONENT_ID_RST;
    end else begin
      seq_r          <= seq_nxt;
      system_id_r    <= system_id_nxt;
      component_id_r <= component_id_nxt;
    end
  end

endmodule

/* hdl/sfb_queue.sv */
// Short report queue between the front end and the frame serializer.
`timescale 1ns / 1ps
module sfb_queue
  import sfb_pkg::*;
#(
  parameter int unsigned DEPTH = SFB_QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  sfb_entry_t    push_entry,
  input  logic          pop,
  output sfb_entry_t    head,
  output sfb_q_status_t q_status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  sfb_entry_t        mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign q_status.full      = (count_r == CNT_W'(DEPTH));
  assign q_status.not_empty = (count_r != '0);
  assign head               = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

/* hdl/sfb_serializer.sv */
// Back end: walks one queued report through its frame bytes and running CRC.
`timescale 1ns / 1ps
module sfb_serializer
  import sfb_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  sfb_entry_t    head,
  input  sfb_q_status_t q_status,
  output logic          pop,
  sfb_out_if.source     out_ch
);

  pos_t        pos_r, pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_byte_r, out_byte_nxt;
  logic        out_last_r, out_last_nxt;
  logic        load;
  logic [7:0]  cur_byte;
  logic [15:0] crc_fin;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_byte = out_byte_r;
  assign out_ch.frame_last = out_last_r;

  assign load    = q_status.not_empty && (!out_valid_r || out_ch.ready);
  assign pop     = load && (pos_r == POS_CRC_HI);
  assign crc_fin = crc_add(crc_r, CRC_MSG_BYTE);

  always_comb begin
    cur_byte = 8'h00;
    crc_nxt  = crc_r;
    unique case (pos_r) inside
      POS_START:  cur_byte = START_BYTE;
      POS_LEN:    cur_byte = PAYLOAD_LEN;
      POS_SEQ:    cur_byte = head.seq;
      POS_SYS:    cur_byte = head.system_id;
      POS_COMP:   cur_byte = head.component_id;
      POS_MSG:    cur_byte = MSG_ID;
      POS_RXE_LO: cur_byte = head.rx_error_count[7:0];
      POS_RXE_HI: cur_byte = head.rx_error_count[15:8];
      POS_COR_LO: cur_byte = head.corrected_count[7:0];
      POS_COR_HI: cur_byte = head.corrected_count[15:8];
      POS_LRSSI:  cur_byte = head.local_rssi;
      POS_RRSSI:  cur_byte = head.remote_rssi;
      POS_RXBUF:  cur_byte = head.rx_buffer_space;
      POS_LNOISE: cur_byte = head.local_noise;
      POS_RNOISE: cur_byte = head.remote_noise;
      POS_CRC_LO: cur_byte = crc_fin[7:0];
      POS_CRC_HI: cur_byte = crc_r[15:8];
      default:    cur_byte = 8'h00;
    endcase
    if (load) begin
      unique case (pos_r) inside
        POS_START:              crc_nxt = CRC_SEED;
        [POS_LEN:POS_RNOISE]:   crc_nxt = crc_add(crc_r, cur_byte);
        POS_CRC_LO:             crc_nxt = crc_fin;
        default:                crc_nxt = crc_r;
      endcase
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (load) begin
      pos_nxt       = (pos_r == POS_CRC_HI) ? POS_START : pos_r + POS_W'(1);
      out_valid_nxt = 1'b1;
      out_byte_nxt  = cur_byte;
      out_last_nxt  = (pos_r == POS_CRC_HI);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_START;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r      <= crc_nxt;
    out_byte_r <= out_byte_nxt;
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_CRC_HI)
    else $error("frame position out of range");

  a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (load && pos_r == POS_CRC_HI) |=> (pos_r == POS_START && out_last_r))
    else $error("last byte did not close the frame");

  a_last_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (load && pos_r != POS_CRC_HI) |=> !out_last_r)
    else $error("last flag raised mid-frame");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_status.not_empty)
    else $error("pop from empty queue");

endmodule

/* test/tb_top.sv */
// Testbench for the radio status frame builder: directed reports, random reports, byte checks.
`timescale 1ns / 1ps
module tb_top;
  import sfb_pkg::*;

  localparam int unsigned CLK_HALF_NS     = 5;
  localparam int unsigned RESET_CYCLES    = 10;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned HOLD_CYCLES     = 150;
  localparam int unsigned MAX_GAP         = 50;
  localparam int unsigned TIMEOUT_NS      = 3_000_000;
  localparam int unsigned BYTES_PER_FRAME = 17;
  localparam int unsigned DIRECTED_ROWS   = 10;
  localparam logic [15:0] CRC_POLY_REFL   = 16'h8408;
  localparam logic [7:0]  REG_UNUSED_LO   = 8'd2;
  localparam logic [7:0]  REG_UNUSED_HI   = 8'hFF;

  typedef struct packed {
    logic [15:0] rx_error_count;
    logic [15:0] corrected_count;
    logic [7:0]  local_rssi;
    logic [7:0]  remote_rssi;
    logic [7:0]  rx_buffer_space;
    logic [7:0]  local_noise;
    logic [7:0]  remote_noise;
    logic [15:0] link_room;
  } report_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } frame_beat_t;

  typedef struct packed {
    report_t    rep;
    logic       typed;
    logic       typed_drop;
    logic [7:0] typed_seq;
  } dir_row_t;

  logic clk;
  logic rst_n;

  sfb_in_if  in_ch ();
  sfb_out_if out_ch ();
  sfb_cfg_if cfg_ch ();

  status_frame_builder_crc16_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  frame_beat_t pending_bytes [$];
  logic [7:0]  seq_model;
  logic [7:0]  sys_id_model;
  logic [7:0]  comp_id_model;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;
  int unsigned fail_count = 0;
  logic        hold_toggle;
  logic        hold_seen;
  int unsigned hold_left;

  dir_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'd17},   1'b1, 1'b0, 8'd0},
    '{'{16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd16},   1'b1, 1'b1, 8'd1},
    '{'{16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF}, 1'b1, 1'b0, 8'd2},
    '{'{16'h0000, 16'h0000, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 16'd0},    1'b1, 1'b1, 8'd3},
    '{'{16'hAAAA, 16'h5555, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 16'h8000}, 1'b1, 1'b0, 8'd4},
    '{'{16'h5555, 16'hAAAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 16'h7FFF}, 1'b1, 1'b0, 8'd5},
    '{'{16'h0001, 16'h8000, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h00, 16'd18},   1'b0, 1'b0, 8'd0},
    '{'{16'h00FF, 16'hFF00, 8'hF0, 8'h0F, 8'hC3, 8'h3C, 8'h99, 16'hFFFE}, 1'b0, 1'b0, 8'd0},
    '{'{16'h1234, 16'hBEEF, 8'd12, 8'd200, 8'd64, 8'd3, 8'd250, 16'd1},   1'b1, 1'b1, 8'd8},
    '{'{16'h1234, 16'hBEEF, 8'd12, 8'd200, 8'd64, 8'd3, 8'd250, 16'd100}, 1'b0, 1'b0, 8'd0}
  };

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    int          k;
    c = crc ^ {8'h00, b};
    for (k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

  function automatic void push_expected_frame(input report_t r, input logic [7:0] seq);
    logic [7:0]  fb [BYTES_PER_FRAME];
    logic [15:0] crc;
    frame_beat_t beat;
    int          k;
    fb[0]  = START_BYTE;
    fb[1]  = PAYLOAD_LEN;
    fb[2]  = seq;
    fb[3]  = sys_id_model;
    fb[4]  = comp_id_model;
    fb[5]  = MSG_ID;
    fb[6]  = r.rx_error_count[7:0];
    fb[7]  = r.rx_error_count[15:8];
    fb[8]  = r.corrected_count[7:0];
    fb[9]  = r.corrected_count[15:8];
    fb[10] = r.local_rssi;
    fb[11] = r.remote_rssi;
    fb[12] = r.rx_buffer_space;
    fb[13] = r.local_noise;
    fb[14] = r.remote_noise;
    crc = CRC_SEED;
    for (k = 1; k < 15; k++) begin
      crc = crc16_step(crc, fb[k]);
    end
    crc = crc16_step(crc, CRC_MSG_BYTE);
    fb[15] = crc[7:0];
    fb[16] = crc[15:8];
    for (k = 0; k < BYTES_PER_FRAME; k++) begin
      beat.frame_byte = fb[k];
      beat.frame_last = (k == BYTES_PER_FRAME - 1);
      pending_bytes.push_back(beat);
    end
  endfunction

  function automatic report_t random_report(input int unsigned drop_pct);
    report_t r;
    r.rx_error_count  = 16'($urandom);
    r.corrected_count = 16'($urandom);
    r.local_rssi      = 8'($urandom);
    r.remote_rssi     = 8'($urandom);
    r.rx_buffer_space = 8'($urandom);
    r.local_noise     = 8'($urandom);
    r.remote_noise    = 8'($urandom);
    if ($urandom_range(0, 99) < drop_pct) begin
      r.link_room = 16'($urandom_range(0, FRAME_LEN - 1));
    end else begin
      r.link_room = 16'($urandom_range(FRAME_LEN, 16'hFFFF));
    end
    return r;
  endfunction

  task automatic send_report(input report_t r, input logic typed, input logic typed_drop,
                             input logic [7:0] typed_seq);
    int unsigned gap;
    logic [7:0]  hdr_seq;
    logic        drop;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < in_idle_pct) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid           <= 1'b1;
    in_ch.rx_error_count  <= r.rx_error_count;
    in_ch.corrected_count <= r.corrected_count;
    in_ch.local_rssi      <= r.local_rssi;
    in_ch.remote_rssi     <= r.remote_rssi;
    in_ch.rx_buffer_space <= r.rx_buffer_space;
    in_ch.local_noise     <= r.local_noise;
    in_ch.remote_noise    <= r.remote_noise;
    in_ch.link_room       <= r.link_room;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    hdr_seq = typed ? typed_seq : seq_model;
    drop    = typed ? typed_drop : (r.link_room < FRAME_LEN);
    if (!drop) push_expected_frame(r, hdr_seq);
    seq_model = seq_model + 8'd1;
  endtask

  task automatic send_random(input int unsigned count, input int unsigned drop_pct);
    repeat (count) send_report(random_report(drop_pct), 1'b0, 1'b0, 8'h00);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    if (idx == REG_SYSTEM_ID) begin
      sys_id_model = val;
    end else if (idx == REG_COMPONENT_ID) begin
      comp_id_model = val;
    end
  endtask

  // drop valid, wait out every expected beat, then idle so any stray beat is caught
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #CLK_HALF_NS clk = ~clk;
  end

  initial begin
    #TIMEOUT_NS;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1) begin
      hold_seen    <= hold_toggle;
      hold_left    <= 0;
      out_ch.ready <= 1'b0;
    end else if (hold_toggle !== hold_seen) begin
      hold_seen    <= hold_toggle;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin : check_beats
    frame_beat_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_bytes.size() == 0) begin
        $error("frame_byte: expected no beat, got 0x%02h", out_ch.frame_byte);
        fail_count++;
      end else begin
        want = pending_bytes.pop_front();
        if (out_ch.frame_byte !== want.frame_byte) begin
          $error("frame_byte: expected 0x%02h, got 0x%02h", want.frame_byte, out_ch.frame_byte);
          fail_count++;
        end
        if (out_ch.frame_last !== want.frame_last) begin
          $error("frame_last: expected %0b, got %0b", want.frame_last, out_ch.frame_last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.rx_error_count  = '0;
    in_ch.corrected_count = '0;
    in_ch.local_rssi      = '0;
    in_ch.remote_rssi     = '0;
    in_ch.rx_buffer_space = '0;
    in_ch.local_noise     = '0;
    in_ch.remote_noise    = '0;
    in_ch.link_room       = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = '0;
    cfg_ch.data           = '0;
    hold_toggle           = 1'b0;
    in_idle_pct           = 0;
    out_stall_pct         = 0;
    seq_model             = 8'd0;
    sys_id_model          = SYSTEM_ID_RST;
    comp_id_model         = COMPONENT_ID_RST;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      send_report(directed_rows[i].rep, directed_rows[i].typed, directed_rows[i].typed_drop,
                  directed_rows[i].typed_seq);
    end
    settle();

    write_reg(REG_SYSTEM_ID, 8'h00);
    write_reg(REG_COMPONENT_ID, 8'hFF);
    write_reg(REG_UNUSED_LO, 8'hA5);
    write_reg(REG_UNUSED_HI, 8'h5A);
    cfg_ch.valid <= 1'b0;
    in_idle_pct   = 75;
    out_stall_pct = 0;
    send_random(30, 15);
    settle();

    write_reg(REG_SYSTEM_ID, 8'hFF);
    write_reg(REG_COMPONENT_ID, 8'h00);
    cfg_ch.valid <= 1'b0;
    in_idle_pct   = 0;
    out_stall_pct = 75;
    send_random(30, 15);
    settle();

    write_reg(REG_SYSTEM_ID, 8'($urandom));
    write_reg(REG_COMPONENT_ID, 8'($urandom));
    cfg_ch.valid <= 1'b0;
    in_idle_pct   = 33;
    out_stall_pct = 33;
    send_random(12, 15);
    settle();
    send_random(12, 15);
    settle();

    write_reg(REG_COMPONENT_ID, 8'($urandom));
    write_reg(REG_SYSTEM_ID, 8'($urandom));
    cfg_ch.valid <= 1'b0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    // hold the receiver while reports keep coming
    hold_toggle <= ~hold_toggle;
    send_random(8, 0);
    send_random(20, 10);

    out_stall_pct = 0;
    settle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/sfb_pkg.sv
hdl/sfb_if.sv
hdl/sfb_front.sv
hdl/sfb_queue.sv
hdl/sfb_serializer.sv
hdl/status_frame_builder_crc16_top.sv
test/tb_top.sv
